[src/seven_segment_command_sequencer_core_defines.svh]
// assertion macros used by the sequencer back end (sscs_back)
// each macro expects signals named clock and reset in the enclosing module
`ifndef SEVEN_SEGMENT_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`define SEVEN_SEGMENT_COMMAND_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define SSCS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SSCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/sscs_pkg.sv]
package sscs_pkg;

   localparam int DIGITS      = 4;
   localparam int QUEUE_DEPTH = 2;

   // command codes
   localparam logic [2:0] CMD_CLEAR   = 3'd0;
   localparam logic [2:0] CMD_PATTERN = 3'd1;
   localparam logic [2:0] CMD_DIGIT   = 3'd2;
   localparam logic [2:0] CMD_SEGMENT = 3'd3;
   localparam logic [2:0] CMD_DECIMAL = 3'd4;
   localparam logic [2:0] CMD_HEX     = 3'd5;
   localparam logic [2:0] CMD_BRIGHT  = 3'd6;

   // bus bytes
   localparam logic [7:0] BYTE_MODE       = 8'h40;
   localparam logic [7:0] BYTE_CTRL       = 8'h48;
   localparam logic [4:0] CTRL_LOW_BITS   = 5'h11;
   localparam logic [7:0] BYTE_DIGIT_BASE = 8'h68;
   localparam logic [7:0] POINT_BIT       = 8'h80;
   localparam logic [7:0] BLANK           = 8'h00;

   // x / 10 == (x * 52429) >> 19 for every 16-bit x
   localparam logic [31:0] DIV10_MUL   = 32'd52429;
   localparam int          DIV10_SHIFT = 19;

   typedef struct packed {
      logic [2:0]  command;
      logic [1:0]  position;
      logic [7:0]  pattern;
      logic [4:0]  digit;
      logic [2:0]  segment;
      logic [15:0] number;
      logic [1:0]  point;
      logic [2:0]  level;
   } req_item_type;

   typedef struct packed {
      logic [7:0] bus_byte;
      logic       start_before;
      logic       stop_after;
      logic       last;
   } rsp_item_type;

   typedef enum logic [2:0] {
      KIND_CLEAR,
      KIND_SINGLE,
      KIND_DECIMAL,
      KIND_HEX,
      KIND_BRIGHT
   } kind_type;

   // classified command as held in the queue
   typedef struct packed {
      kind_type    kind;
      logic [1:0]  position;
      logic [7:0]  bitmap;
      logic [15:0] number;
      logic [1:0]  point;
      logic [2:0]  level;
   } desc_type;

   // segment table, indexes of 16 and above are blank
   function automatic logic [7:0] glyph(input logic [4:0] idx);
      logic [7:0] g;
      case (idx)
         5'd0:    g = 8'h3f;
         5'd1:    g = 8'h06;
         5'd2:    g = 8'h5b;
         5'd3:    g = 8'h4f;
         5'd4:    g = 8'h66;
         5'd5:    g = 8'h6d;
         5'd6:    g = 8'h7d;
         5'd7:    g = 8'h07;
         5'd8:    g = 8'h7f;
         5'd9:    g = 8'h6f;
         5'd10:   g = 8'h77;
         5'd11:   g = 8'h7c;
         5'd12:   g = 8'h39;
         5'd13:   g = 8'h5e;
         5'd14:   g = 8'h79;
         5'd15:   g = 8'h71;
         default: g = BLANK;
      endcase
      return g;
   endfunction

endpackage

[src/sscs_front.sv]
module sscs_front (
   input  logic                    req_valid,
   output logic                    req_stall,
   input  sscs_pkg::req_item_type  req_data,
   input  logic                    queue_full,
   output logic                    push,
   output sscs_pkg::desc_type      push_data
);
   import sscs_pkg::*;

   // take an item whenever the queue has room, undefined codes are dropped
   assign req_stall = queue_full;

   always_comb begin
      push                = req_valid && !queue_full;
      push_data.kind      = KIND_SINGLE;
      push_data.position  = req_data.position;
      push_data.bitmap    = BLANK;
      push_data.number    = req_data.number;
      push_data.point     = req_data.point;
      push_data.level     = req_data.level;
      case (req_data.command)
         CMD_CLEAR: begin
            push_data.kind = KIND_CLEAR;
         end
         CMD_PATTERN: begin
            push_data.bitmap = req_data.pattern;
         end
         CMD_DIGIT: begin
            push_data.bitmap = glyph(req_data.digit);
         end
         CMD_SEGMENT: begin
            push_data.bitmap = 8'(1) << req_data.segment;
         end
         CMD_DECIMAL: begin
            push_data.kind = KIND_DECIMAL;
         end
         CMD_HEX: begin
            push_data.kind = KIND_HEX;
         end
         CMD_BRIGHT: begin
            push_data.kind = KIND_BRIGHT;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

[src/sscs_queue.sv]
module sscs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sscs_pkg::desc_type  push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output sscs_pkg::desc_type  head_data
);
   import sscs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   desc_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/sscs_back.sv]
`include "seven_segment_command_sequencer_core_defines.svh"

module sscs_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  sscs_pkg::desc_type      head_data,
   output logic                    pop,
   input  logic [2:0]              brightness,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sscs_pkg::rsp_item_type  rsp_data
);
   import sscs_pkg::*;

   logic [2:0]   byte_idx_ff, byte_idx_in;
   logic [1:0]   group_ff, group_in;
   logic [15:0]  value_ff, value_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   logic         advance;
   logic         group_end;
   logic         run_end;
   logic [15:0]  value;
   logic [31:0]  product;
   logic [12:0]  quotient;
   logic [3:0]   q10_low;
   logic [3:0]   dec_digit;
   logic [1:0]   position;
   logic [7:0]   data_byte;
   rsp_item_type next_item;

   // a byte moves whenever the output register is free or being emptied
   assign advance = head_valid && (!rsp_valid_ff || !rsp_stall);

   // digit extraction, one digit per position group
   assign value     = (group_ff == '0) ? head_data.number : value_ff;
   assign product   = 32'(value) * DIV10_MUL;
   assign quotient  = product[DIV10_SHIFT+12:DIV10_SHIFT];
   assign q10_low   = 4'({quotient[0], 3'b000}) + 4'({quotient[2:0], 1'b0});
   assign dec_digit = value[3:0] - q10_low;

   // group length and run length
   always_comb begin
      if (head_data.kind == KIND_BRIGHT) begin
         group_end = (byte_idx_ff == 3'd1);
      end else begin
         group_end = (byte_idx_ff == 3'd4);
      end
      run_end = group_end && ((head_data.kind == KIND_BRIGHT) ||
                              (head_data.kind == KIND_SINGLE) ||
                              (group_ff == 2'(DIGITS - 1)));
   end

   // position and data byte of the current group
   always_comb begin
      position  = ~group_ff;
      data_byte = BLANK;
      value_in  = value >> 4;
      case (head_data.kind)
         KIND_CLEAR: begin
            position = group_ff;
         end
         KIND_SINGLE: begin
            position  = head_data.position;
            data_byte = head_data.bitmap;
         end
         KIND_DECIMAL: begin
            data_byte = glyph({1'b0, dec_digit});
            if ((head_data.point != '0) && (group_ff == head_data.point)) begin
               data_byte = data_byte | POINT_BIT;
            end
            value_in = 16'(quotient);
         end
         KIND_HEX: begin
            data_byte = glyph({1'b0, value[3:0]});
         end
         default: begin
            data_byte = BLANK;
         end
      endcase
   end

   // byte selection within a group
   always_comb begin
      next_item = '{bus_byte: BLANK, start_before: 1'b0, stop_after: 1'b0, last: run_end};
      if (head_data.kind == KIND_BRIGHT) begin
         case (byte_idx_ff)
            3'd0: begin
               next_item.bus_byte     = BYTE_CTRL;
               next_item.start_before = 1'b1;
            end
            default: begin
               next_item.bus_byte   = {head_data.level, CTRL_LOW_BITS};
               next_item.stop_after = 1'b1;
            end
         endcase
      end else begin
         case (byte_idx_ff)
            3'd0: begin
               next_item.bus_byte     = BYTE_MODE;
               next_item.start_before = 1'b1;
               next_item.stop_after   = 1'b1;
            end
            3'd1: begin
               next_item.bus_byte     = BYTE_CTRL;
               next_item.start_before = 1'b1;
            end
            3'd2: begin
               next_item.bus_byte   = {brightness, CTRL_LOW_BITS};
               next_item.stop_after = 1'b1;
            end
            3'd3: begin
               next_item.bus_byte     = BYTE_DIGIT_BASE | {5'b00000, ~position, 1'b0};
               next_item.start_before = 1'b1;
            end
            default: begin
               next_item.bus_byte   = data_byte;
               next_item.stop_after = (head_data.kind != KIND_CLEAR) ||
                                      (group_ff == 2'(DIGITS - 1));
            end
         endcase
      end
   end

   // counters
   always_comb begin
      byte_idx_in = byte_idx_ff;
      group_in    = group_ff;
      if (advance) begin
         if (group_end) begin
            byte_idx_in = '0;
            group_in    = run_end ? '0 : group_ff + 1'b1;
         end else begin
            byte_idx_in = byte_idx_ff + 1'b1;
         end
      end
   end

   assign pop = advance && run_end;

   // output register
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = advance ? next_item : rsp_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_idx_ff  <= '0;
         group_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         byte_idx_ff  <= byte_idx_in;
         group_ff     <= group_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (advance && group_end) begin
         value_ff <= value_in;
      end
   end

   // checks
   `SSCS_ASSERT_NOW(byte_idx_range, head_valid, byte_idx_ff <= 3'd4,
      "byte index past the end of a group")
   `SSCS_ASSERT_NEXT(run_end_clears, advance && run_end,
      (group_ff == '0) && (byte_idx_ff == '0), "counters not cleared after a run")
   `SSCS_ASSERT_NEXT(run_end_marks_last, advance && run_end,
      rsp_valid_ff && rsp_ff.last && rsp_ff.stop_after, "final byte not flagged")

endmodule

[src/seven_segment_command_sequencer_core.sv]
// Seven-segment command sequencer: turns each display command into the run of
// two-wire bus bytes for a four-digit driver, one byte per result item, each
// flagged with start-before, stop-after and last-of-run. The output register
// releases one byte per cycle while rsp_stall is low. A command yields 20
// bytes for clear, decimal and hex, 5 for pattern, digit and segment, 2 for
// brightness, and none for the undefined code 7. A two-entry queue sits
// between the command decoder and the byte sequencer, so further commands
// are taken while a run is still going out. The brightness register
// (reset 7) is written through the csr port, which is always ready; write
// it only while no run is pending.
module seven_segment_command_sequencer_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  sscs_pkg::req_item_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sscs_pkg::rsp_item_type  rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_data
);
   import sscs_pkg::*;

   logic [2:0] brightness_ff, brightness_in;
   logic       queue_full;
   logic       push;
   desc_type   push_data;
   logic       pop;
   logic       head_valid;
   desc_type   head_data;

   // brightness register
   assign csr_ready     = 1'b1;
   assign brightness_in = csr_valid ? csr_data : brightness_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= 3'd7;
      end else begin
         brightness_ff <= brightness_in;
      end
   end

   sscs_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   sscs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   sscs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .brightness (brightness_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
